// ===== sv/imu_serial_frame_decoder_top_defines.svh =====
// assertion macros for the imu serial frame decoder
`ifndef IMU_SERIAL_FRAME_DECODER_TOP_DEFINES_SVH
`define IMU_SERIAL_FRAME_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define IMU_SFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imu frame decoder check failed");
// antecedent implies consequent in the next cycle
`define IMU_SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imu frame decoder check failed");
`else
`define IMU_SFD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define IMU_SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/imu_sfd_pkg.sv =====
// shared constants and types for the imu serial frame decoder
`default_nettype none

package imu_sfd_pkg;

    localparam int FRAME_LEN = 11;
    localparam int FILL_W    = 4;

    typedef logic [7:0]        byte_t;
    typedef logic [FILL_W-1:0] fill_t;

    localparam byte_t HEADER_BYTE = 8'h55;
    localparam byte_t KIND_RATE   = 8'h52;
    localparam byte_t KIND_ANGLE  = 8'h53;

    localparam fill_t FILL_FULL = fill_t'(FRAME_LEN);
    localparam fill_t FILL_ZERO = fill_t'(0);

    typedef enum logic {
        PKT_RATE  = 1'b0,
        PKT_ANGLE = 1'b1
    } pkt_kind_t;

endpackage

`default_nettype wire

// ===== sv/imu_serial_frame_decoder_top.sv =====
// imu serial frame decoder: byte collector, checksum check and field decode
//
//  channel   signals                                   direction
//  -------   ---------------------------------------   ---------
//  input     in_valid, in_ready, rx_byte               in
//  result    out_valid, out_ready, packet_kind,        out
//            value_x, value_y, value_z, yaw_relative
//  config    zero_yaw_wr_en, zero_yaw                  in
//
//  one byte per cycle sustained while the result side is ready: an input register feeds the frame store,
//  and one pass of decode logic (ten-byte sum tree and compare) goes straight into the result register
//  a result is loaded when the byte that follows a full frame leaves the input register
//  reset clears the fill count, the valid flags and zero_yaw; frame bytes are
//  left as they are since only a full frame is ever read
//  a stalled result blocks the decode stage only, the input register still
//  holds one more byte, so both sides run at full rate when ready is high
`default_nettype none

`include "imu_serial_frame_decoder_top_defines.svh"

module imu_serial_frame_decoder_top
    import imu_sfd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               zero_yaw_wr_en,
    input  wire logic signed [15:0] zero_yaw,
    // byte input
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic        [7:0]  rx_byte,
    // decoded result
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic               packet_kind,
    output      logic signed [15:0] value_x,
    output      logic signed [15:0] value_y,
    output      logic signed [15:0] value_z,
    output      logic signed [15:0] yaw_relative
);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [15:0] zero_yaw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_yaw_reg <= '0;
        end
        else if (zero_yaw_wr_en)
        begin
            zero_yaw_reg <= zero_yaw;
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic  in_valid_reg;
    logic  in_valid_next;
    byte_t in_byte_reg;
    logic  advance;       // decode stage consumes the held byte
    logic  out_valid_reg;
    logic  out_valid_next;

    // the decode stage moves whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // frame store and fill count
    // ------------------------------------------------------------------
    byte_t frame_store_reg [FRAME_LEN];
    fill_t fill_count_reg;
    fill_t fill_count_next;
    fill_t wr_idx;
    logic  frame_full;

    assign frame_full = (fill_count_reg == FILL_FULL);

    // a header byte or a full store closes the frame, the new byte starts the next
    always_comb
    begin
        if ((in_byte_reg == HEADER_BYTE) || frame_full)
        begin
            wr_idx = FILL_ZERO;
        end
        else
        begin
            wr_idx = fill_count_reg;
        end
        fill_count_next = fill_count_reg;
        if (advance)
        begin
            fill_count_next = wr_idx + fill_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= FILL_ZERO;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    for (genvar i = 0; i < FRAME_LEN; i++)
    begin : g_store
        always_ff @(posedge clk)
        begin
            if (advance && (wr_idx == fill_t'(i)))
            begin
                frame_store_reg[i] <= in_byte_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // checksum and decode of the held frame
    // ------------------------------------------------------------------
    byte_t       sum_01, sum_23, sum_45, sum_67, sum_89;
    byte_t       sum_0123, sum_4567, sum_all;
    logic        sum_ok;
    logic        kind_rate;
    logic        kind_angle;
    logic        decode_ok;
    logic        out_load;
    logic [15:0] raw_x, raw_y, raw_z;
    logic [15:0] yaw_rel_calc;

    // balanced sum tree over bytes 0..9, mod 256
    assign sum_01   = frame_store_reg[0] + frame_store_reg[1];
    assign sum_23   = frame_store_reg[2] + frame_store_reg[3];
    assign sum_45   = frame_store_reg[4] + frame_store_reg[5];
    assign sum_67   = frame_store_reg[6] + frame_store_reg[7];
    assign sum_89   = frame_store_reg[8] + frame_store_reg[9];
    assign sum_0123 = sum_01 + sum_23;
    assign sum_4567 = sum_45 + sum_67;
    assign sum_all  = sum_0123 + sum_4567 + sum_89;
    assign sum_ok   = (sum_all == frame_store_reg[10]);

    assign kind_rate  = (frame_store_reg[1] == KIND_RATE);
    assign kind_angle = (frame_store_reg[1] == KIND_ANGLE);

    // unknown kind bytes pass the checksum but give nothing
    assign decode_ok = frame_full && sum_ok && (kind_rate || kind_angle);
    assign out_load  = advance && decode_ok;

    // little endian fields, low byte first
    assign raw_x = {frame_store_reg[3], frame_store_reg[2]};
    assign raw_y = {frame_store_reg[5], frame_store_reg[4]};
    assign raw_z = {frame_store_reg[7], frame_store_reg[6]};

    // wraps mod 2^16, matching the +-pi wrap of the angle scale
    assign yaw_rel_calc = kind_angle ? (raw_z - zero_yaw_reg) : 16'h0000;

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    pkt_kind_t   kind_reg;
    logic [15:0] x_reg, y_reg, z_reg, yaw_rel_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind_reg    <= kind_angle ? PKT_ANGLE : PKT_RATE;
            x_reg       <= raw_x;
            y_reg       <= raw_y;
            z_reg       <= raw_z;
            yaw_rel_reg <= yaw_rel_calc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign packet_kind  = kind_reg;
    assign value_x      = x_reg;
    assign value_y      = y_reg;
    assign value_z      = z_reg;
    assign yaw_relative = yaw_rel_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a result is only ever produced from a complete frame
    `IMU_SFD_ASSERT_SAME(a_load_needs_full, clk, rst_n, out_load, frame_full)
    // a header byte always restarts the store with itself as byte 0
    `IMU_SFD_ASSERT_NEXT(a_header_restarts, clk, rst_n,
        advance && (in_byte_reg == HEADER_BYTE), fill_count_reg == fill_t'(1))
    // after a byte is stored the fill count lies between one and a full frame
    `IMU_SFD_ASSERT_NEXT(a_fill_range, clk, rst_n, advance,
        (fill_count_reg != FILL_ZERO) && (fill_count_reg <= FILL_FULL))

endmodule

`default_nettype wire
